[hdl/spds_pkg.sv]
// ----------------------------------------------------------------------------
// spds_pkg
// Shared types and constants of the scan point distance segmenter.
// ----------------------------------------------------------------------------
package spds_pkg;

    localparam int DEF_MAX_SEGMENTS = 1024;
    localparam int DEF_COORD_BITS   = 16;

    // Fixed widths of the result fields and of the threshold register.
    localparam int IDX_W = 10;
    localparam int CNT_W = 11;
    localparam int THR_W = 32;

    localparam logic [THR_W-1:0] THR_RESET = 32'd10000;

    localparam int QUEUE_DEPTH = 4;

    // Result kinds carried on tuser.
    localparam logic KIND_POINT   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Classification of one accepted request, handed from front to back.
    typedef struct packed {
        logic keep;       // point is kept and gives a point result
        logic first_pt;   // kept point is the first one of its scan
        logic scan_end;   // request closes the scan
        logic any_point;  // the scan holds a kept point after this request
    } ctrl_t;

endpackage

[hdl/scan_point_distance_segmenter.sv]
// ----------------------------------------------------------------------------
// scan_point_distance_segmenter
// Splits a stream of laser scan points into segments at distance jumps.
// ----------------------------------------------------------------------------
// Points enter on the s_ stream: x and y in tdata, the finite flag in tuser
// and the end-of-scan mark in tlast. Results leave on the m_ stream with the
// kind in tuser (point or scan summary) and the last-result flag in tlast.
// The squared distance threshold is written on the cfg_ channel, which is
// always ready; write it only while no request is in flight.
// One point is taken per cycle while the queue has room. A kept point gives
// one result, a scan end a summary as well. The first result of a request
// passes the queue, the squaring multipliers, the threshold compare and the
// result stage registers before it is offered.
// A four-entry queue separates the input side from the result side, so
// s_tready stays high while results wait, and only drops once the queue
// fills behind a stalled m_tready. Nothing is lost or repeated on a stall.
// Reset empties the queue and the pipeline, starts a fresh scan and loads
// a threshold of 10000 square millimetres.
// ----------------------------------------------------------------------------
module scan_point_distance_segmenter #(
    parameter int MAX_SEGMENTS = spds_pkg::DEF_MAX_SEGMENTS,
    parameter int COORD_BITS   = spds_pkg::DEF_COORD_BITS
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          s_tvalid,
    output logic                                          s_tready,
    // pos_x, pos_y, zero fill
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]             s_tdata,
    // finite
    input  logic                                          s_tuser,
    input  logic                                          s_tlast,
    output logic                                          m_tvalid,
    input  logic                                          m_tready,
    // out_x, out_y, segment_index, new_segment, segment_count,
    // wraps_to_first, zero fill
    output logic [((2*COORD_BITS+spds_pkg::IDX_W+spds_pkg::CNT_W+2+7)/8)*8-1:0]
                                                          m_tdata,
    // kind
    output logic                                          m_tuser,
    output logic                                          m_tlast,
    input  logic                                          cfg_valid,
    output logic                                          cfg_ready,
    input  logic [spds_pkg::THR_W-1:0]                    cfg_data
);

    localparam int DW     = COORD_BITS + 1;
    localparam int CTRL_W = $bits(spds_pkg::ctrl_t);
    localparam int QW     = CTRL_W + 2 * COORD_BITS + 4 * DW;
    localparam int OUT_W  = 2 * COORD_BITS + spds_pkg::IDX_W + spds_pkg::CNT_W + 2;
    localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

    logic [spds_pkg::THR_W-1:0]   thr_reg;

    logic                         f_push;
    logic                         q_ready;
    spds_pkg::ctrl_t              f_ctrl;
    logic signed [COORD_BITS-1:0] f_x;
    logic signed [COORD_BITS-1:0] f_y;
    logic [DW-1:0]                f_adx;
    logic [DW-1:0]                f_ady;
    logic [DW-1:0]                f_wdx;
    logic [DW-1:0]                f_wdy;
    logic [QW-1:0]                q_in;
    logic [QW-1:0]                q_out;
    logic                         q_valid;
    logic                         q_pop;
    spds_pkg::ctrl_t              b_ctrl;
    logic signed [COORD_BITS-1:0] b_x;
    logic signed [COORD_BITS-1:0] b_y;
    logic [DW-1:0]                b_adx;
    logic [DW-1:0]                b_ady;
    logic [DW-1:0]                b_wdx;
    logic [DW-1:0]                b_wdy;
    logic [OUT_W-1:0]             out_word;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= spds_pkg::THR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            thr_reg <= cfg_data;
        end
    end

    spds_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_x       (s_tdata[COORD_BITS-1:0]),
        .in_y       (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .in_finite  (s_tuser),
        .in_end     (s_tlast),
        .push       (f_push),
        .push_ready (q_ready),
        .push_ctrl  (f_ctrl),
        .push_x     (f_x),
        .push_y     (f_y),
        .push_adx   (f_adx),
        .push_ady   (f_ady),
        .push_wdx   (f_wdx),
        .push_wdy   (f_wdy)
    );

    assign q_in = {f_ctrl, f_x, f_y, f_adx, f_ady, f_wdx, f_wdy};

    spds_queue #(
        .WIDTH (QW),
        .DEPTH (spds_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (f_push),
        .wr_data    (q_in),
        .push_ready (q_ready),
        .pop        (q_pop),
        .pop_data   (q_out),
        .pop_valid  (q_valid)
    );

    assign {b_ctrl, b_x, b_y, b_adx, b_ady, b_wdx, b_wdy} = q_out;

    spds_back #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .COORD_BITS   (COORD_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .threshold_sq (thr_reg),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_ctrl       (b_ctrl),
        .q_x          (b_x),
        .q_y          (b_y),
        .q_adx        (b_adx),
        .q_ady        (b_ady),
        .q_wdx        (b_wdx),
        .q_wdy        (b_wdy),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_kind     (m_tuser),
        .out_last     (m_tlast),
        .out_word     (out_word)
    );

    assign m_tdata = OUT_TW'(out_word);

endmodule

[hdl/spds_queue.sv]
// ----------------------------------------------------------------------------
// spds_queue
// Small register queue between the classifying front and the result back.
// ----------------------------------------------------------------------------
module spds_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             push_ready,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             pop_valid
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];

    assign do_push = push && push_ready;
    assign do_pop  = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[hdl/spds_front.sv]
// ----------------------------------------------------------------------------
// spds_front
// Accepts scan points, marks empty or non-finite readings as not kept,
// and forms the coordinate differences to the previous kept point and
// between the first and last kept points of the scan.
// ----------------------------------------------------------------------------
module spds_front #(
    parameter int COORD_BITS = spds_pkg::DEF_COORD_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [COORD_BITS-1:0] in_x,
    input  logic signed [COORD_BITS-1:0] in_y,
    input  logic                         in_finite,
    input  logic                         in_end,
    output logic                         push,
    input  logic                         push_ready,
    output spds_pkg::ctrl_t              push_ctrl,
    output logic signed [COORD_BITS-1:0] push_x,
    output logic signed [COORD_BITS-1:0] push_y,
    output logic [COORD_BITS:0]          push_adx,
    output logic [COORD_BITS:0]          push_ady,
    output logic [COORD_BITS:0]          push_wdx,
    output logic [COORD_BITS:0]          push_wdy
);

    localparam int DW = COORD_BITS + 1;

    logic signed [COORD_BITS-1:0] prev_x_reg;
    logic signed [COORD_BITS-1:0] prev_y_reg;
    logic signed [COORD_BITS-1:0] first_x_reg;
    logic signed [COORD_BITS-1:0] first_y_reg;
    logic                         have_reg;
    logic                         have_next;

    logic                         keep;
    logic signed [COORD_BITS-1:0] fx;
    logic signed [COORD_BITS-1:0] fy;
    logic signed [COORD_BITS-1:0] lx;
    logic signed [COORD_BITS-1:0] ly;
    logic signed [DW-1:0]         dx;
    logic signed [DW-1:0]         dy;
    logic signed [DW-1:0]         wx;
    logic signed [DW-1:0]         wy;

    assign in_ready = push_ready;
    assign push     = in_valid && push_ready;
    assign keep     = in_finite && ((in_x != '0) || (in_y != '0));

    // The wrap check at scan end compares the first kept point with the last
    // one, either of which may be the point arriving now.
    assign fx = have_reg ? first_x_reg : in_x;
    assign fy = have_reg ? first_y_reg : in_y;
    assign lx = keep ? in_x : prev_x_reg;
    assign ly = keep ? in_y : prev_y_reg;

    always_comb
    begin
        dx = DW'(in_x) - DW'(prev_x_reg);
        dy = DW'(in_y) - DW'(prev_y_reg);
        wx = DW'(fx) - DW'(lx);
        wy = DW'(fy) - DW'(ly);
        push_adx = dx[DW-1] ? -dx : dx;
        push_ady = dy[DW-1] ? -dy : dy;
        push_wdx = wx[DW-1] ? -wx : wx;
        push_wdy = wy[DW-1] ? -wy : wy;
    end

    assign push_x              = in_x;
    assign push_y              = in_y;
    assign push_ctrl.keep      = keep;
    assign push_ctrl.first_pt  = keep && !have_reg;
    assign push_ctrl.scan_end  = in_end;
    assign push_ctrl.any_point = have_reg || keep;

    always_comb
    begin
        have_next = have_reg;
        if (push)
        begin
            if (in_end)
            begin
                have_next = 1'b0;
            end
            else if (keep)
            begin
                have_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg    <= 1'b0;
            prev_x_reg  <= '0;
            prev_y_reg  <= '0;
            first_x_reg <= '0;
            first_y_reg <= '0;
        end
        else
        begin
            have_reg <= have_next;
            if (push && keep)
            begin
                prev_x_reg  <= in_x;
                prev_y_reg  <= in_y;
                first_x_reg <= fx;
                first_y_reg <= fy;
            end
        end
    end

endmodule

[hdl/spds_back.sv]
// ----------------------------------------------------------------------------
// spds_back
// Squares the queued differences, compares against the threshold, keeps the
// segment counter and presents point and summary results.
// ----------------------------------------------------------------------------
module spds_back #(
    parameter int MAX_SEGMENTS = spds_pkg::DEF_MAX_SEGMENTS,
    parameter int COORD_BITS   = spds_pkg::DEF_COORD_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [spds_pkg::THR_W-1:0]           threshold_sq,
    input  logic                                 q_valid,
    output logic                                 q_pop,
    input  spds_pkg::ctrl_t                      q_ctrl,
    input  logic signed [COORD_BITS-1:0]         q_x,
    input  logic signed [COORD_BITS-1:0]         q_y,
    input  logic [COORD_BITS:0]                  q_adx,
    input  logic [COORD_BITS:0]                  q_ady,
    input  logic [COORD_BITS:0]                  q_wdx,
    input  logic [COORD_BITS:0]                  q_wdy,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 out_kind,
    output logic                                 out_last,
    output logic [2*COORD_BITS+spds_pkg::IDX_W+spds_pkg::CNT_W+1:0] out_word
);

    localparam int DW    = COORD_BITS + 1;
    localparam int SQ_W  = 2 * DW;
    localparam int SUM_W = SQ_W + 1;
    localparam int CMP_W = (SUM_W > spds_pkg::THR_W) ? SUM_W : spds_pkg::THR_W;
    localparam int CW    = $clog2(MAX_SEGMENTS + 1);
    localparam int IDX_W = spds_pkg::IDX_W;
    localparam int CNT_W = spds_pkg::CNT_W;

    // Square stage.
    logic                         v1_reg;
    spds_pkg::ctrl_t              ctrl1_reg;
    logic signed [COORD_BITS-1:0] x1_reg;
    logic signed [COORD_BITS-1:0] y1_reg;
    logic [SQ_W-1:0]              sq_px_reg;
    logic [SQ_W-1:0]              sq_py_reg;
    logic [SQ_W-1:0]              sq_wx_reg;
    logic [SQ_W-1:0]              sq_wy_reg;

    // Compare stage.
    logic                         v2_reg;
    spds_pkg::ctrl_t              ctrl2_reg;
    logic signed [COORD_BITS-1:0] x2_reg;
    logic signed [COORD_BITS-1:0] y2_reg;
    logic                         close_pt_reg;
    logic                         close_wr_reg;
    logic [SUM_W-1:0]             sum_pt;
    logic [SUM_W-1:0]             sum_wr;

    // Result stage.
    logic                         pend_pt_reg;
    logic                         pend_sum_reg;
    logic signed [COORD_BITS-1:0] pt_x_reg;
    logic signed [COORD_BITS-1:0] pt_y_reg;
    logic [IDX_W-1:0]             pt_idx_reg;
    logic                         pt_new_reg;
    logic                         pt_last_reg;
    logic [CNT_W-1:0]             sum_count_reg;
    logic                         sum_wraps_reg;
    logic [CW-1:0]                seg_cnt_reg;
    logic [CW-1:0]                seg_cnt_next;

    logic                         fire;
    logic                         res_free;
    logic                         load3;
    logic                         adv2;
    logic                         adv1;
    logic                         opens;
    logic [CW-1:0]                cnt_after;
    logic [CW-1:0]                idx;
    logic [CW-1:0]                count;
    logic                         wraps;

    assign fire     = out_valid && out_ready;
    // The result stage is free when empty or when its final result leaves now.
    assign res_free = !(pend_pt_reg || pend_sum_reg)
                      || (fire && !(pend_pt_reg && pend_sum_reg));
    assign load3    = v2_reg && res_free;
    assign adv2     = !v2_reg || res_free;
    assign adv1     = !v1_reg || adv2;
    assign q_pop    = q_valid && adv1;

    assign sum_pt = SUM_W'(sq_px_reg) + SUM_W'(sq_py_reg);
    assign sum_wr = SUM_W'(sq_wx_reg) + SUM_W'(sq_wy_reg);

    always_comb
    begin
        opens = ctrl2_reg.first_pt || !close_pt_reg;
        cnt_after = seg_cnt_reg;
        if (ctrl2_reg.keep && opens && (seg_cnt_reg < CW'(MAX_SEGMENTS)))
        begin
            cnt_after = seg_cnt_reg + 1'b1;
        end
        idx   = cnt_after - 1'b1;
        count = ctrl2_reg.any_point ? cnt_after : '0;
        wraps = (count >= CW'(2)) && close_wr_reg;
        if (wraps)
        begin
            count = count - 1'b1;
        end
        seg_cnt_next = ctrl2_reg.scan_end ? '0 : cnt_after;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            pend_pt_reg  <= 1'b0;
            pend_sum_reg <= 1'b0;
            seg_cnt_reg  <= '0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= q_valid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
            if (load3)
            begin
                pend_pt_reg  <= ctrl2_reg.keep;
                pend_sum_reg <= ctrl2_reg.scan_end;
                seg_cnt_reg  <= seg_cnt_next;
            end
            else if (fire)
            begin
                if (pend_pt_reg)
                begin
                    pend_pt_reg <= 1'b0;
                end
                else
                begin
                    pend_sum_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            ctrl1_reg <= q_ctrl;
            x1_reg    <= q_x;
            y1_reg    <= q_y;
            sq_px_reg <= q_adx * q_adx;
            sq_py_reg <= q_ady * q_ady;
            sq_wx_reg <= q_wdx * q_wdx;
            sq_wy_reg <= q_wdy * q_wdy;
        end
        if (adv2 && v1_reg)
        begin
            ctrl2_reg    <= ctrl1_reg;
            x2_reg       <= x1_reg;
            y2_reg       <= y1_reg;
            close_pt_reg <= CMP_W'(sum_pt) < CMP_W'(threshold_sq);
            close_wr_reg <= CMP_W'(sum_wr) < CMP_W'(threshold_sq);
        end
        if (load3)
        begin
            pt_x_reg      <= x2_reg;
            pt_y_reg      <= y2_reg;
            pt_idx_reg    <= IDX_W'(idx);
            pt_new_reg    <= opens;
            pt_last_reg   <= !ctrl2_reg.scan_end;
            sum_count_reg <= CNT_W'(count);
            sum_wraps_reg <= wraps;
        end
    end

    // A point result always leaves before the summary of the same request.
    assign out_valid = pend_pt_reg || pend_sum_reg;
    assign out_kind  = pend_pt_reg ? spds_pkg::KIND_POINT : spds_pkg::KIND_SUMMARY;
    assign out_last  = pend_pt_reg ? pt_last_reg : 1'b1;
    assign out_word  = pend_pt_reg
                       ? {1'b0, {CNT_W{1'b0}}, pt_new_reg, pt_idx_reg, pt_y_reg, pt_x_reg}
                       : {sum_wraps_reg, sum_count_reg, 1'b0, {IDX_W{1'b0}},
                          {COORD_BITS{1'b0}}, {COORD_BITS{1'b0}}};

endmodule
